@@ rtl/core/signed_mod_rem_unit_macros.svh @@
// Assertion macros for the signed modulus unit.
`ifndef SIGNED_MOD_REM_UNIT_MACROS_SVH
`define SIGNED_MOD_REM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/smr_pkg.sv @@
package smr_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int LATENCY       = DATA_WIDTH + 3;
   localparam int LAT_CNT_WIDTH = $clog2(LATENCY + 1);

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic {
      CMD_MOD = 1'b0,
      CMD_REM = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      logic     a_neg;
      logic     b_neg;
      logic     zero_div;
      word_type dividend;
      word_type divisor;
   } ctl_type;

   typedef struct packed {
      word_type rem;
      word_type num;
      word_type mag_divisor;
   } div_type;

endpackage

@@ rtl/core/smr_prep.sv @@
module smr_prep
   import smr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid,
   input  logic                         cmd,
   input  logic signed [DATA_WIDTH-1:0] dividend,
   input  logic signed [DATA_WIDTH-1:0] divisor,
   output logic                         valid_out,
   output ctl_type                      ctl_out,
   output div_type                      div_out
);

   logic    valid_ff;
   ctl_type ctl_in, ctl_ff;
   div_type div_in, div_ff;

   always_comb begin
      ctl_in.cmd      = cmd_type'(cmd);
      ctl_in.a_neg    = dividend[DATA_WIDTH-1];
      ctl_in.b_neg    = divisor[DATA_WIDTH-1];
      ctl_in.zero_div = (divisor == '0);
      ctl_in.dividend = word_type'(dividend);
      ctl_in.divisor  = word_type'(divisor);
      div_in.rem      = '0;
      div_in.num      = ctl_in.a_neg ? (~word_type'(dividend) + word_type'(1))
                                     : word_type'(dividend);
      div_in.mag_divisor = ctl_in.b_neg ? (~word_type'(divisor) + word_type'(1))
                                        : word_type'(divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
      div_ff <= div_in;
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign div_out   = div_ff;

endmodule

@@ rtl/core/smr_div_stage.sv @@
module smr_div_stage
   import smr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    valid_in,
   input  ctl_type ctl_in,
   input  div_type div_in,
   output logic    valid_out,
   output ctl_type ctl_out,
   output div_type div_out
);

   logic                  valid_ff;
   ctl_type               ctl_ff;
   div_type               div_ff;
   div_type               div_nx_in;
   logic [DATA_WIDTH:0]   trial;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial = {div_in.rem, div_in.num[DATA_WIDTH-1]} - {1'b0, div_in.mag_divisor};
      div_nx_in.mag_divisor = div_in.mag_divisor;
      div_nx_in.num         = {div_in.num[DATA_WIDTH-2:0], 1'b0};
      if (!trial[DATA_WIDTH]) begin
         div_nx_in.rem = trial[DATA_WIDTH-1:0];
      end else begin
         div_nx_in.rem = {div_in.rem[DATA_WIDTH-2:0], div_in.num[DATA_WIDTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
      div_ff <= div_nx_in;
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign div_out   = div_ff;

endmodule

@@ rtl/core/smr_post.sv @@
module smr_post
   import smr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_in,
   input  ctl_type                      ctl_in,
   input  word_type                     rem_in,
   output logic                         valid_out,
   output logic signed [DATA_WIDTH-1:0] result,
   output logic                         zero_divisor
);

   logic     valid1_ff, valid2_ff;
   ctl_type  ctl1_ff;
   word_type srem_in, srem_ff;
   logic     fix_in, fix_ff;
   word_type result_in, result_ff;
   logic     zero_ff;

   // stage 1: give the remainder the dividend's sign
   always_comb begin
      srem_in = ctl_in.a_neg ? (~rem_in + word_type'(1)) : rem_in;
      fix_in  = (ctl_in.cmd == CMD_MOD) && (rem_in != '0) && (ctl_in.a_neg != ctl_in.b_neg);
   end

   // stage 2: floored correction and divide-by-zero rule
   always_comb begin
      if (ctl1_ff.zero_div) begin
         result_in = (ctl1_ff.cmd == CMD_MOD) ? ctl1_ff.dividend : '0;
      end else if (fix_ff) begin
         result_in = srem_ff + ctl1_ff.divisor;
      end else begin
         result_in = srem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl1_ff   <= ctl_in;
      srem_ff   <= srem_in;
      fix_ff    <= fix_in;
      result_ff <= result_in;
      zero_ff   <= ctl1_ff.zero_div;
   end

   assign valid_out    = valid2_ff;
   assign result       = result_ff;
   assign zero_divisor = zero_ff;

endmodule

@@ rtl/core/signed_mod_rem_unit.sv @@
// Signed floored modulo / truncated remainder, fully pipelined.
// Pipeline from start to rsp_valid, in order:
//   one operand stage, one restoring-divide stage per bit, two sign-fix stages.
// Throughput: one transfer per cycle; busy is never raised, the receiver cannot stall.
// Reset: synchronous, active high; clears all pipeline valid bits, no results in flight.
module signed_mod_rem_unit
   import smr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_dividend,
   input  logic signed [DATA_WIDTH-1:0] req_divisor,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result,
   output logic                         rsp_zero_divisor
);

   logic    stg_valid [DATA_WIDTH+1];
   ctl_type stg_ctl   [DATA_WIDTH+1];
   div_type stg_div   [DATA_WIDTH+1];

   assign busy = 1'b0;

   smr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .valid     (start && !busy),
      .cmd       (req_cmd),
      .dividend  (req_dividend),
      .divisor   (req_divisor),
      .valid_out (stg_valid[0]),
      .ctl_out   (stg_ctl[0]),
      .div_out   (stg_div[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
      smr_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stg_valid[i]),
         .ctl_in    (stg_ctl[i]),
         .div_in    (stg_div[i]),
         .valid_out (stg_valid[i+1]),
         .ctl_out   (stg_ctl[i+1]),
         .div_out   (stg_div[i+1])
      );
   end

   smr_post u_post (
      .clock        (clock),
      .reset        (reset),
      .valid_in     (stg_valid[DATA_WIDTH]),
      .ctl_in       (stg_ctl[DATA_WIDTH]),
      .rem_in       (stg_div[DATA_WIDTH].rem),
      .valid_out    (rsp_valid),
      .result       (rsp_result),
      .zero_divisor (rsp_zero_divisor)
   );

endmodule

@@ rtl/core/smr_checker.sv @@
`include "signed_mod_rem_unit_macros.svh"

module smr_checker
   import smr_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_cmd,
   input logic signed [DATA_WIDTH-1:0] req_dividend,
   input logic signed [DATA_WIDTH-1:0] req_divisor,
   input logic                         rsp_valid,
   input logic signed [DATA_WIDTH-1:0] rsp_result,
   input logic                         rsp_zero_divisor
);

   logic [LAT_CNT_WIDTH-1:0] since_rst_ff;
   logic                     warm;

   always_ff @(posedge clock) begin
      if (reset) begin
         since_rst_ff <= '0;
      end else if (since_rst_ff != LAT_CNT_WIDTH'(LATENCY)) begin
         since_rst_ff <= since_rst_ff + LAT_CNT_WIDTH'(1);
      end
   end

   assign warm = (since_rst_ff == LAT_CNT_WIDTH'(LATENCY));

   `SMR_ASSERT_IMPL(a_fixed_latency, clock, reset, warm,
      rsp_valid == $past(start && !busy, LATENCY), "result strobe off fixed latency")
   `SMR_ASSERT_IMPL(a_zero_flag, clock, reset, warm && rsp_valid,
      rsp_zero_divisor == ($past(req_divisor, LATENCY) == '0), "zero flag mismatch")
   `SMR_ASSERT_IMPL(a_rem_by_zero, clock, reset,
      warm && rsp_valid && rsp_zero_divisor && $past(req_cmd, LATENCY),
      rsp_result == '0, "remainder by zero not 0")
   `SMR_ASSERT_IMPL(a_mod_sign, clock, reset,
      warm && rsp_valid && !rsp_zero_divisor && !$past(req_cmd, LATENCY) && rsp_result != '0,
      rsp_result[DATA_WIDTH-1] == $past(req_divisor[DATA_WIDTH-1], LATENCY),
      "modulo sign differs from divisor")
   `SMR_ASSERT_IMPL(a_rem_sign, clock, reset,
      warm && rsp_valid && !rsp_zero_divisor && $past(req_cmd, LATENCY) && rsp_result != '0,
      rsp_result[DATA_WIDTH-1] == $past(req_dividend[DATA_WIDTH-1], LATENCY),
      "remainder sign differs from dividend")

endmodule

bind signed_mod_rem_unit smr_checker u_smr_checker (.*);
